// File: design/sha1sh_pkg.sv
package sha1sh_pkg;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] SCHED_LEN  = 7'd16;
    localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

// File: design/sha1_stream_hasher.sv
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_stall     i_data_byte, i_byte_valid, i_end_of_message
// digest    out        o_out_valid / i_out_stall   o_digest_word, o_word_index, o_last_word
//
// a byte request is taken while idle; the 64th byte of a block starts the shared round unit,
// which runs 80 rounds at one per cycle, then a fold step adds the result into the chaining words
// end of message: padding is shifted in one byte a cycle, with one or two compressions,
// then five digest words, one per cycle unless stalled
// o_in_stall stays high during a mid-message compression, and from an end
// request until the last digest word is taken
// i_rst_n is synchronous; it restores the initial chaining words and empties the message
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_total, n_total;
    logic [6:0]  r_rnd, n_rnd;
    logic        r_padding, n_padding;
    logic        r_pad_sent, n_pad_sent;
    logic        r_len, n_len;
    logic [2:0]  r_idx, n_idx;

    logic        do_shift;
    logic        start_blk;
    logic [7:0]  shift_byte;
    logic [31:0] f_val, k_val, w_val, sum;

    // round function, constant and schedule word
    always_comb begin
        if (r_rnd inside {[7'd0:7'd19]}) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1sh_pkg::K0;
        end else if (r_rnd inside {[7'd20:7'd39]}) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1sh_pkg::K1;
        end else if (r_rnd inside {[7'd40:7'd59]}) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1sh_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1sh_pkg::K3;
        end
        if (r_rnd < sha1sh_pkg::SCHED_LEN) begin
            w_val = r_w[0];
        end else begin
            w_val = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
            w_val = {w_val[30:0], w_val[31]};
        end
        sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_val;
    end

    always_comb begin
        n_state    = r_state;
        n_w        = r_w;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_d        = r_d;
        n_e        = r_e;
        n_h        = r_h;
        n_fill     = r_fill;
        n_total    = r_total;
        n_rnd      = r_rnd;
        n_padding  = r_padding;
        n_pad_sent = r_pad_sent;
        n_len      = r_len;
        n_idx      = r_idx;
        do_shift   = 1'b0;
        start_blk  = 1'b0;
        shift_byte = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_padding = i_end_of_message;
                    if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                    if (i_byte_valid) begin
                        do_shift   = 1'b1;
                        shift_byte = i_data_byte;
                        n_total    = r_total + 61'd1;
                        start_blk  = (r_fill == sha1sh_pkg::FILL_LAST);
                    end
                end
            end
            S_PAD: begin
                do_shift  = 1'b1;
                start_blk = (r_fill == sha1sh_pkg::FILL_LAST);
                if (!r_pad_sent) begin
                    shift_byte = sha1sh_pkg::PAD_BYTE;
                    n_pad_sent = 1'b1;
                end else if (r_len || r_fill == sha1sh_pkg::LEN_POS) begin
                    // length goes out big-endian, bit count is total times eight
                    shift_byte = r_total[60:53];
                    n_total    = {r_total[52:0], 8'h00};
                    n_len      = 1'b1;
                end
            end
            S_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_val;
                n_a     = sum;
                n_b     = r_a;
                n_c     = {r_b[1:0], r_b[31:2]};
                n_d     = r_c;
                n_e     = r_d;
                n_rnd   = r_rnd + 7'd1;
                if (r_rnd == sha1sh_pkg::ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_h[4] = r_h[4] + r_e;
                n_idx  = 3'd0;
                if (!r_padding) begin
                    n_state = S_IDLE;
                end else if (r_len) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_idx == sha1sh_pkg::LAST_INDEX) begin
                        n_h        = sha1sh_pkg::H_INIT;
                        n_fill     = 6'd0;
                        n_total    = 61'd0;
                        n_padding  = 1'b0;
                        n_pad_sent = 1'b0;
                        n_len      = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // block buffer shifts left a byte, byte 0 ends in the top of word 0
        if (do_shift) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], shift_byte};
            n_fill  = r_fill + 6'd1;
        end

        if (start_blk) begin
            n_state = S_ROUND;
            n_rnd   = 7'd0;
            n_a     = r_h[0];
            n_b     = r_h[1];
            n_c     = r_h[2];
            n_d     = r_h[3];
            n_e     = r_h[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_rnd <= n_rnd;
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_h        <= sha1sh_pkg::H_INIT;
            r_fill     <= 6'd0;
            r_total    <= 61'd0;
            r_padding  <= 1'b0;
            r_pad_sent <= 1'b0;
            r_len      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_h        <= n_h;
            r_fill     <= n_fill;
            r_total    <= n_total;
            r_padding  <= n_padding;
            r_pad_sent <= n_pad_sent;
            r_len      <= n_len;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == sha1sh_pkg::LAST_INDEX);

endmodule

// File: design/sha1sh_checker.sv
module sha1sh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_digest_word)))
        else $error("digest word changed under stall");

    // no request taken while the digest goes out
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request channel open during digest");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == sha1sh_pkg::LAST_INDEX)))
        else $error("last word flag out of step with index");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_word) |=>
            (o_out_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest index did not advance");

    a_end_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after last digest word");

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (.*);

// File: tb/sv/sha1_stream_hasher_tb.sv
module sha1_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    class sha1_scoreboard;
        logic [31:0]  chain_words [5];
        logic [7:0]   block_bytes [64];
        logic [5:0]   fill_count;
        logic [60:0]  byte_total;
        t_digest_word digest_queue [$];
        int           error_count;
        int           words_checked;
        int           messages;
        int           bytes_hashed;

        function new();
            error_count   = 0;
            words_checked = 0;
            messages      = 0;
            bytes_hashed  = 0;
            restart();
        endfunction

        function void restart();
            int i;
            for (i = 0; i < 5; i++) begin
                chain_words[i] = sha1sh_pkg::H_INIT[i];
            end
            for (i = 0; i < 64; i++) begin
                block_bytes[i] = 8'h00;
            end
            fill_count = '0;
            byte_total = '0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        function int pending();
            return digest_queue.size();
        endfunction

        function void compress();
            logic [31:0] sched [80];
            logic [31:0] va, vb, vc, vd, ve, fn, kc, tmp;
            int r;
            for (r = 0; r < 16; r++) begin
                sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                            block_bytes[4*r+2], block_bytes[4*r+3]};
            end
            for (r = 16; r < 80; r++) begin
                tmp = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
                sched[r] = {tmp[30:0], tmp[31]};
            end
            va = chain_words[0];
            vb = chain_words[1];
            vc = chain_words[2];
            vd = chain_words[3];
            ve = chain_words[4];
            for (r = 0; r < 80; r++) begin
                if (r < 20) begin
                    fn = (vb & vc) | (~vb & vd);
                    kc = sha1sh_pkg::K0;
                end else if (r < 40) begin
                    fn = vb ^ vc ^ vd;
                    kc = sha1sh_pkg::K1;
                end else if (r < 60) begin
                    fn = (vb & vc) | (vb & vd) | (vc & vd);
                    kc = sha1sh_pkg::K2;
                end else begin
                    fn = vb ^ vc ^ vd;
                    kc = sha1sh_pkg::K3;
                end
                tmp = {va[26:0], va[31:27]} + fn + ve + kc + sched[r];
                ve = vd;
                vd = vc;
                vc = {vb[1:0], vb[31:2]};
                vb = va;
                va = tmp;
            end
            chain_words[0] += va;
            chain_words[1] += vb;
            chain_words[2] += vc;
            chain_words[3] += vd;
            chain_words[4] += ve;
        endfunction

        function void push_byte(logic [7:0] value);
            block_bytes[fill_count] = value;
            fill_count = fill_count + 6'd1;
            if (fill_count == 6'd0) begin
                compress();
            end
        endfunction

        function void note_request(logic [7:0] data, logic has_byte, logic ends_msg);
            logic [63:0]  bit_len;
            t_digest_word exp;
            int i;
            if (has_byte) begin
                push_byte(data);
                byte_total = byte_total + 61'd1;
                bytes_hashed++;
            end
            if (!ends_msg) begin
                return;
            end
            bit_len = {byte_total, 3'b000};
            push_byte(sha1sh_pkg::PAD_BYTE);
            while (fill_count != sha1sh_pkg::LEN_POS) begin
                push_byte(8'h00);
            end
            for (i = 0; i < 8; i++) begin
                push_byte(bit_len[63 - 8*i -: 8]);
            end
            for (i = 0; i < 5; i++) begin
                exp.word  = chain_words[i];
                exp.index = 3'(i);
                exp.last  = (3'(i) == sha1sh_pkg::LAST_INDEX);
                digest_queue.push_back(exp);
            end
            messages++;
            restart();
        endfunction

        task check_digest(logic [31:0] word, logic [2:0] index, logic last);
            t_digest_word exp;
            if (digest_queue.size() == 0) begin
                report($sformatf("digest word %h index %0d with nothing expected", word, index));
                return;
            end
            exp = digest_queue.pop_front();
            words_checked++;
            if (word !== exp.word) begin
                report($sformatf("word %0d: digest %h, expected %h", exp.index, word, exp.word));
            end
            if (index !== exp.index) begin
                report($sformatf("word index %0d, expected %0d", index, exp.index));
            end
            if (last !== exp.last) begin
                report($sformatf("word %0d: last flag %b, expected %b", exp.index, last, exp.last));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_end_of_message;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_scoreboard sb;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_phase = 0;
    int cycle_count = 0;

    sha1_stream_hasher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // digest side: check taken words, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_digest(o_digest_word, o_word_index, o_last_word);
        end
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(20, 120);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                i_out_stall <= (stall_phase[3:0] >= 4'd9);
            end
        endcase
    end

    task automatic send_request(input logic [7:0] data, input logic has_byte,
                                input logic ends_msg);
        int gap;
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_byte_valid     <= has_byte;
        i_end_of_message <= ends_msg;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        sb.note_request(data, has_byte, ends_msg);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold requests back until every digest word owed has been taken
    task automatic drain_digests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_message(input int len);
        logic tail_on_end;
        int   i;
        tail_on_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_request(8'($urandom), 1'b0, 1'b0);
            end
            send_request(8'($urandom), 1'b1, tail_on_end && (i == len - 1));
        end
        if (!tail_on_end) begin
            send_request(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_data_byte      <= 8'h00;
        i_byte_valid     <= 1'b0;
        i_end_of_message <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then an ignored byte before another empty one
        send_request(8'h5a, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // single byte carried on the end request
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        // "abc", then again with an ignored byte and a bare end request
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h33, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        drain_digests();

        // a full block, then a tail long enough that the pad spills into a further block
        send_message($urandom_range(120, 124));

        drain_digests();
        repeat (200) @(posedge i_clk);

        $display("hashed %0d messages, %0d message bytes, including an empty message,",
                 sb.messages, sb.bytes_hashed);
        $display("a full block and a spilled pad; %0d digest words checked",
                 sb.words_checked);
        if (sb.error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
